@@ design/shared_buffer_multi_queue_unit_macros.svh @@
// Assertion macros for the shared buffer multi-queue unit.
// Expects clk and rst in the scope of the module that uses them.
`ifndef SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH

// Consequent in the same cycle as the antecedent.
`define SBMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sbmq_pkg.sv @@
// Package for the shared buffer multi-queue unit: sizes, codes, transaction types.
// No dependencies.
`default_nettype none

package sbmq_pkg;

  localparam int DEPTH  = 16;
  localparam int QUEUES = 4;
  localparam int DATA_W = 32;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW     = $clog2(DEPTH + 1);
  localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef logic [AW-1:0]            addr_t;
  typedef logic [PW-1:0]            ptr_t;
  typedef logic [QW-1:0]            qidx_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam ptr_t  NIL        = PW'(DEPTH);
  localparam data_t EMPTY_DATA = '1;

  typedef enum logic {
    KIND_ENQ,
    KIND_DEQ
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_e;

  typedef enum logic [1:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] queue_id;
    data_t      data_in;
  } cmd_t;

  typedef struct packed {
    status_e status;
    data_t   data_out;
  } result_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    ptr_t  wdata;
    addr_t raddr;
  } link_req_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } data_req_t;

  function automatic qidx_t queue_index(input logic [1:0] id);
    logic [7:0] r;
    r = {6'd0, id};
    for (int i = 0; i < 4; i++) begin
      if (r >= 8'(QUEUES)) begin
        r = r - 8'(QUEUES);
      end
    end
    return QW'(r);
  endfunction

endpackage

`default_nettype wire

@@ design/sbmq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/sbmq_ctrl.sv @@
// Sequencer for the shared buffer multi-queue: queue pointers, free head,
// link-store initialization and read-modify-write control. Uses sbmq_pkg.
`default_nettype none

module sbmq_ctrl
  import sbmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result,
  output link_req_t link_req,
  input  wire ptr_t link_rdata,
  output data_req_t data_req,
  input  wire data_t data_rdata
);

  fsm_e    fsm, fsm_next;
  addr_t   init_idx;
  ptr_t    head [QUEUES];
  ptr_t    tail [QUEUES];
  ptr_t    free_head;
  kind_e   op_kind;
  qidx_t   op_q;
  data_t   op_data;
  ptr_t    op_slot;
  result_t result_next;
  logic    accept;
  qidx_t   q_in;
  ptr_t    slot_in;
  logic    op_fail;

  assign accept  = start && (fsm == FSM_IDLE);
  assign q_in    = queue_index(cmd.queue_id);
  assign slot_in = (cmd.kind == KIND_ENQ) ? free_head : head[q_in];
  assign op_fail = (op_slot == NIL);

  always_comb begin
    fsm_next = fsm;
    case (fsm)
      FSM_INIT: begin
        if (init_idx == AW'(DEPTH - 1)) begin
          fsm_next = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          fsm_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        fsm_next = FSM_IDLE;
      end
      default: begin
        fsm_next = FSM_INIT;
      end
    endcase
  end

  always_comb begin
    busy           = (fsm != FSM_IDLE);
    link_req       = '0;
    data_req       = '0;
    link_req.raddr = slot_in[AW-1:0];
    data_req.raddr = slot_in[AW-1:0];
    case (fsm)
      FSM_INIT: begin
        link_req.we    = 1'b1;
        link_req.waddr = init_idx;
        link_req.wdata = ptr_t'(init_idx) + ptr_t'(1);
      end
      FSM_EXEC: begin
        if (!op_fail) begin
          if (op_kind == KIND_ENQ) begin
            link_req.we    = (head[op_q] != NIL);
            link_req.waddr = tail[op_q][AW-1:0];
            link_req.wdata = op_slot;
            data_req.we    = 1'b1;
            data_req.waddr = op_slot[AW-1:0];
            data_req.wdata = op_data;
          end else begin
            link_req.we    = 1'b1;
            link_req.waddr = op_slot[AW-1:0];
            link_req.wdata = free_head;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_next.status   = ST_OK;
    result_next.data_out = '0;
    if (op_kind == KIND_ENQ) begin
      if (op_fail) begin
        result_next.status = ST_FULL;
      end
    end else if (op_fail) begin
      result_next.status   = ST_EMPTY;
      result_next.data_out = EMPTY_DATA;
    end else begin
      result_next.data_out = data_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FSM_INIT;
      init_idx  <= '0;
      free_head <= '0;
      done      <= 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      fsm  <= fsm_next;
      done <= (fsm == FSM_EXEC);
      if (fsm == FSM_INIT) begin
        init_idx <= init_idx + AW'(1);
      end
      if ((fsm == FSM_EXEC) && !op_fail) begin
        if (op_kind == KIND_ENQ) begin
          free_head <= link_rdata;
          if (head[op_q] == NIL) begin
            head[op_q] <= op_slot;
          end
          tail[op_q] <= op_slot;
        end else begin
          free_head <= op_slot;
          if (op_slot == tail[op_q]) begin
            head[op_q] <= NIL;
            tail[op_q] <= NIL;
          end else begin
            head[op_q] <= link_rdata;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= cmd.kind;
      op_q    <= q_in;
      op_data <= cmd.data_in;
      op_slot <= slot_in;
    end
    if (fsm == FSM_EXEC) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ design/shared_buffer_multi_queue_unit.sv @@
// Result: an accepted transaction enters the EXEC state, and done is registered from
// that state. A new transaction is accepted only in the idle state, after the link RAM
// read and its write-back. The receiver cannot stall; each done strobe shows for one cycle.
// Reset: synchronous; busy stays high while the link RAM is initialized into the
// free list, one entry a cycle.
// Depends on sbmq_pkg, sbmq_ctrl, sbmq_ram and the assertion macro header.
`default_nettype none

`include "shared_buffer_multi_queue_unit_macros.svh"

module shared_buffer_multi_queue_unit
  import sbmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  link_req_t link_req;
  data_req_t data_req;
  ptr_t      link_rdata;
  data_t     data_rdata;

  sbmq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .link_req   (link_req),
    .link_rdata (link_rdata),
    .data_req   (data_req),
    .data_rdata (data_rdata)
  );

  sbmq_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_req.we),
    .waddr (data_req.waddr),
    .wdata (data_req.wdata),
    .raddr (data_req.raddr),
    .rdata (data_rdata)
  );

  `SBMQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted transaction")
  `SBMQ_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `SBMQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe on two cycles")
  `SBMQ_ASSERT_NOW(a_full_zero, done && (result.status == ST_FULL), result.data_out == '0,
                   "full result with nonzero data")

endmodule

`default_nettype wire
